### sv/arc_pkg.sv
// shared types, codes and sizes for the arp resolution cache
package arc_pkg;

  localparam int ENTRIES = 16;
  localparam int CNT_W   = $clog2(ENTRIES + 1);

  // input kinds
  localparam logic [1:0] KIND_RESOLVE = 2'd0;
  localparam logic [1:0] KIND_PACKET  = 2'd1;
  localparam logic [1:0] KIND_LOOKUP  = 2'd2;

  // result status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FAIL      = 2'd1;
  localparam logic [1:0] ST_PENDING   = 2'd2;
  localparam logic [1:0] ST_NOT_FOUND = 2'd3;

  // frame requests
  localparam logic [1:0] SEND_NONE    = 2'd0;
  localparam logic [1:0] SEND_REQUEST = 2'd1;
  localparam logic [1:0] SEND_REPLY   = 2'd2;

  // arp header values
  localparam logic [15:0] ARP_HW_ETH     = 16'd1;
  localparam logic [15:0] ARP_PROTO_IPV4 = 16'h0800;
  localparam logic [7:0]  ARP_HW_LEN     = 8'd6;
  localparam logic [7:0]  ARP_PROTO_LEN  = 8'd4;
  localparam logic [15:0] ARP_OP_REQUEST = 16'd1;
  localparam logic [15:0] ARP_OP_REPLY   = 16'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_LOCAL_IP      = 2'd0;
  localparam logic [1:0] CFG_LOCAL_MAC     = 2'd1;
  localparam logic [1:0] CFG_ADDRESS_VALID = 2'd2;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] ip;
    logic [47:0] mac;
    logic [15:0] hw_type;
    logic [15:0] proto_type;
    logic [7:0]  hw_len;
    logic [7:0]  proto_len;
    logic [15:0] opcode;
  } arc_in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [1:0]  send;
    logic [31:0] dest_ip;
    logic [47:0] dest_mac;
    logic [47:0] found_mac;
  } arc_out_t;

  // operation broadcast to every cell
  typedef enum logic [1:0] {
    CMD_IDLE,
    CMD_COMPARE,
    CMD_ALLOC,
    CMD_REPLY
  } cell_op_t;

  typedef struct packed {
    cell_op_t    op;
    logic [31:0] ip;
    logic [47:0] mac;
  } cell_cmd_t;

  // hit information handed from cell to cell
  typedef struct packed {
    logic        hit;
    logic        resolved;
    logic [47:0] mac;
  } chain_t;

endpackage

### sv/arc_in_if.sv
// input channel of the arp resolution cache
interface arc_in_if;
  import arc_pkg::*;

  logic    valid;
  logic    ready;
  arc_in_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### sv/arc_out_if.sv
// result channel of the arp resolution cache
interface arc_out_if;
  import arc_pkg::*;

  logic     valid;
  logic     ready;
  arc_out_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### sv/arp_resolution_cache.sv
// top level of the arp resolution cache: control, result register and the row of cells
//
//  channel | kind   | handshake        | payload
//  in_ch   | sink   | valid / ready    | kind, ip, mac, hw_type, proto_type, hw_len,
//          |        |                  | proto_len, opcode
//  out_ch  | source | valid / ready    | status, send, dest_ip, dest_mac, found_mac
//  cfg_*   | write  | cfg_we           | cfg_idx, cfg_wdata
//
// each transaction: the accept cycle broadcasts the ip to every cell, which registers its
// compare; in the exec state, once the output register has room, the hit ripples down the
// cell row, the result is decided and the table is updated.
// a result held in the output register does not block the next input transaction;
// the decide cycle only waits while that register is still full.
// reset clears the fill count, the control state and address_valid; entries need no
// clearing pass since only cells below the fill count ever match.
module arp_resolution_cache (
  input  logic        clk,
  input  logic        rst_n,
  arc_in_if.sink      in_ch,
  arc_out_if.source   out_ch,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_idx,
  input  logic [47:0] cfg_wdata
);
  import arc_pkg::*;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  state_t     state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  arc_out_t   out_data_r, out_data_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  arc_in_t    item_r;
  logic       addr_valid_r;

  logic       in_fire;
  logic       out_free;
  cell_op_t   exec_op;
  arc_out_t   result;
  cell_cmd_t  cmd;
  logic       pkt_ok;

  logic [ENTRIES-1:0] live;
  logic [ENTRIES-1:0] sel_new;
  logic [ENTRIES-1:0] hits;
  chain_t             chain_w [ENTRIES+1];

  assign in_ch.ready  = (state_r == S_IDLE);
  assign in_fire      = in_ch.valid && in_ch.ready;
  assign out_free     = !out_valid_r || out_ch.ready;
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;

  // only address_valid changes behaviour; local ip and mac writes are not stored by this
  // block
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      addr_valid_r <= 1'b0;
    end else if (cfg_we && (cfg_idx == CFG_ADDRESS_VALID)) begin
      addr_valid_r <= cfg_wdata[0];
    end
  end

  // row of cells
  assign chain_w[0] = '0;

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    assign live[i]    = count_r > CNT_W'(i);
    assign sel_new[i] = count_r == CNT_W'(i);

    arc_cell u_cell (
      .clk       (clk),
      .cmd       (cmd),
      .live      (live[i]),
      .sel_new   (sel_new[i]),
      .chain_in  (chain_w[i]),
      .chain_out (chain_w[i+1]),
      .hit       (hits[i])
    );
  end

  assign pkt_ok = (item_r.hw_type == ARP_HW_ETH) && (item_r.proto_type == ARP_PROTO_IPV4)
               && (item_r.hw_len == ARP_HW_LEN) && (item_r.proto_len == ARP_PROTO_LEN);

  // decide the result and the table update from the hit chain
  always_comb begin
    result  = '0;
    exec_op = CMD_IDLE;
    case (item_r.kind)
      KIND_RESOLVE: begin
        if (!addr_valid_r) begin
          result.status = ST_FAIL;
        end else if (chain_w[ENTRIES].hit) begin
          result.status = ST_OK;
        end else if (count_r >= CNT_W'(ENTRIES)) begin
          // table full
          result.status = ST_FAIL;
        end else begin
          exec_op        = CMD_ALLOC;
          result.send    = SEND_REQUEST;
          result.dest_ip = item_r.ip;
        end
      end
      KIND_PACKET: begin
        if (pkt_ok && (item_r.opcode == ARP_OP_REQUEST)) begin
          // answer without checking the target address
          result.send     = SEND_REPLY;
          result.dest_ip  = item_r.ip;
          result.dest_mac = item_r.mac;
        end else if (pkt_ok && (item_r.opcode == ARP_OP_REPLY)) begin
          exec_op = CMD_REPLY;
        end
      end
      KIND_LOOKUP: begin
        if (!chain_w[ENTRIES].hit) begin
          result.status = ST_NOT_FOUND;
        end else if (chain_w[ENTRIES].resolved) begin
          result.status    = ST_OK;
          result.found_mac = chain_w[ENTRIES].mac;
        end else begin
          result.status = ST_PENDING;
        end
      end
      default: begin
      end
    endcase
  end

  // command broadcast to the cells
  always_comb begin
    cmd.op  = CMD_IDLE;
    cmd.ip  = item_r.ip;
    cmd.mac = item_r.mac;
    if ((state_r == S_IDLE) && in_fire) begin
      cmd.op = CMD_COMPARE;
      cmd.ip = in_ch.data.ip;
    end else if ((state_r == S_EXEC) && out_free) begin
      cmd.op = exec_op;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    count_nxt     = count_r;
    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (out_free) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
          out_data_nxt  = result;
          if (exec_op == CMD_ALLOC) begin
            count_nxt = count_r + CNT_W'(1);
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      count_r     <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      count_r     <= count_nxt;
      out_data_r  <= out_data_nxt;
      if (in_fire) begin
        item_r <= in_ch.data;
      end
    end
  end

  // fill count never passes the table size
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(ENTRIES))
    else $error("fill count beyond table size");

  // ips in the table are unique, so at most one cell hits
  a_single_hit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EXEC) |-> $onehot0(hits))
    else $error("more than one cell hit");

  // an accepted transaction moves on to the decide cycle
  a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (state_r == S_EXEC))
    else $error("accepted transaction not decided");

  // the decide cycle with room in the output register always delivers a result
  a_exec_out: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_EXEC) && out_free) |=> (out_valid_r && (state_r == S_IDLE)))
    else $error("decided transaction gave no result");

endmodule

### sv/arc_cell.sv
// one table entry of the arp cache with its compare and hit chain stage
module arc_cell (
  input  logic               clk,
  input  arc_pkg::cell_cmd_t cmd,
  input  logic               live,
  input  logic               sel_new,
  input  arc_pkg::chain_t    chain_in,
  output arc_pkg::chain_t    chain_out,
  output logic               hit
);
  import arc_pkg::*;

  logic [31:0] ip_r;
  logic [47:0] mac_r;
  logic        req_r;
  logic        res_r;
  logic        hit_r;

  always_ff @(posedge clk) begin
    case (cmd.op)
      CMD_COMPARE: begin
        hit_r <= live && (cmd.ip == ip_r);
      end
      CMD_ALLOC: begin
        if (sel_new) begin
          ip_r  <= cmd.ip;
          req_r <= 1'b1;
          res_r <= 1'b0;
        end
      end
      CMD_REPLY: begin
        if (hit_r) begin
          if (req_r) begin
            mac_r <= cmd.mac;
          end
          res_r <= 1'b1;
          req_r <= 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  // table ips are unique, so at most one cell takes over the chain
  always_comb begin
    if (hit_r) begin
      chain_out.hit      = 1'b1;
      chain_out.resolved = res_r;
      chain_out.mac      = mac_r;
    end else begin
      chain_out = chain_in;
    end
  end

  assign hit = hit_r;

endmodule
